### rtl/irtfp_pkg.sv
package irtfp_pkg;

    // default size of the sensor register space
    localparam int unsigned REGISTER_SPACE_DEF = 16;

    // frame layout
    localparam logic [7:0]  FUNC_READ   = 8'h03;
    localparam int unsigned HDR_BYTES   = 4;
    localparam int unsigned MEAS_BYTES  = 7;
    localparam int unsigned MEAS_IDX_W  = 3;

    // configuration register indexes and reset values
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTE      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPTURE_REGISTER = 1'd1;
    localparam logic [7:0] HEADER_BYTE_RST      = 8'd164;
    localparam logic [3:0] CAPTURE_REGISTER_RST = 4'd7;

    // result status codes
    typedef enum logic [1:0] {
        ST_GOOD_LATCH = 2'd0,
        ST_GOOD_OTHER = 2'd1,
        ST_BAD_CKSUM  = 2'd2
    } t_status;

    // input item
    typedef struct packed {
        logic [7:0] rx_byte;
    } t_rx_item;

    // result item
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  emissivity_raw;
        logic [15:0] object_temp_centi;
        logic [15:0] ambient_temp_centi;
        logic [15:0] body_temp_centi;
    } t_result;

    // completed frame passed from parser to result stage
    typedef struct packed {
        t_status                      status;
        logic [MEAS_BYTES-1:0][7:0]   meas;
    } t_frame_evt;

endpackage

### rtl/irtfp_stream_if.sv
interface irtfp_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/ir_thermometer_frame_parser_top.sv
// infrared thermometer frame parser
// i_rx carries one received serial byte per transfer (valid/ready). frames are
// header, function 0x03, start register, length, data bytes and an additive
// checksum; the parser tracks position and running sum one byte at a time.
// o_res carries one result per completed frame: a status and the held
// emissivity and object, ambient and body temperatures (0.01 degree).
// i_cfg_we/i_cfg_index/i_cfg_wdata write header_byte (index 0) and
// capture_register (index 1); write them only while the block is idle.
// throughput: one byte per cycle while the frame queue is not full, set by the
// byte parser in the front stage. the checksum byte pushes its frame into the
// two-entry frame queue; from there it moves into the output register, which
// drives o_res.valid.
// when the receiver stalls, the output register holds its result and up to two
// more completed frames wait in the queue; i_rx.ready falls only once the
// queue is full.
// reset (synchronous, active low) returns the parser to header search, clears
// the held measurement to zero, empties the queue and the output register and
// loads header_byte 164 and capture_register 7.
module ir_thermometer_frame_parser_top #(
    parameter int unsigned REGISTER_SPACE = irtfp_pkg::REGISTER_SPACE_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [irtfp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [irtfp_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    irtfp_stream_if.sink                      i_rx,
    irtfp_stream_if.source                    o_res
);
    import irtfp_pkg::*;

    logic [7:0] r_header_byte;
    logic [3:0] r_capture_register;
    logic       evt_push;
    logic       evt_full;
    logic       evt_valid;
    logic       evt_pop;
    t_frame_evt front_evt;
    t_frame_evt queue_evt;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_byte      <= HEADER_BYTE_RST;
            r_capture_register <= CAPTURE_REGISTER_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HEADER_BYTE:      r_header_byte      <= i_cfg_wdata;
                CFG_CAPTURE_REGISTER: r_capture_register <= i_cfg_wdata[3:0];
                default: begin
                end
            endcase
        end
    end

    // byte parser
    irtfp_front #(
        .REGISTER_SPACE (REGISTER_SPACE)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_header_byte      (r_header_byte),
        .i_capture_register (r_capture_register),
        .i_rx               (i_rx),
        .i_evt_full         (evt_full),
        .o_evt_push         (evt_push),
        .o_evt              (front_evt)
    );

    // completed frame queue
    irtfp_evt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (evt_push),
        .i_evt   (front_evt),
        .o_full  (evt_full),
        .o_valid (evt_valid),
        .i_pop   (evt_pop),
        .o_evt   (queue_evt)
    );

    // measurement latch and result register
    irtfp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt_valid (evt_valid),
        .i_evt       (queue_evt),
        .o_evt_pop   (evt_pop),
        .o_res       (o_res)
    );

endmodule

### rtl/irtfp_front.sv
module irtfp_front #(
    parameter int unsigned REGISTER_SPACE = irtfp_pkg::REGISTER_SPACE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [7:0]            i_header_byte,
    input  logic [3:0]            i_capture_register,
    irtfp_stream_if.sink          i_rx,
    input  logic                  i_evt_full,
    output logic                  o_evt_push,
    output irtfp_pkg::t_frame_evt o_evt
);
    import irtfp_pkg::*;

    localparam int unsigned SW = $clog2(REGISTER_SPACE);
    localparam int unsigned PW = $clog2(REGISTER_SPACE + HDR_BYTES);

    localparam logic [PW-1:0] P_HDR   = PW'(0);
    localparam logic [PW-1:0] P_FUNC  = PW'(1);
    localparam logic [PW-1:0] P_START = PW'(2);
    localparam logic [PW-1:0] P_LEN   = PW'(3);
    localparam logic [8:0]    SPACE9  = 9'(REGISTER_SPACE);

    logic [PW-1:0] r_pos, n_pos;
    logic [SW-1:0] r_start, n_start;
    logic [SW-1:0] r_len, n_len;
    logic [7:0]    r_sum, n_sum;
    logic [MEAS_BYTES-1:0][7:0] r_stage, n_stage;

    logic          accept;
    logic [7:0]    b;
    logic [7:0]    sum_b;
    logic [PW-1:0] data_idx;
    logic          in_data;
    logic          start_ok;
    logic          len_ok;
    t_status       status;

    assign i_rx.ready = ~i_evt_full;
    assign accept     = i_rx.valid & ~i_evt_full;
    assign b          = i_rx.data.rx_byte;
    assign sum_b      = r_sum + b;
    assign data_idx   = r_pos - PW'(HDR_BYTES);
    assign in_data    = r_pos < (PW'(r_len) + PW'(HDR_BYTES));
    assign start_ok   = {1'b0, b} < SPACE9;
    assign len_ok     = ({1'b0, b} + 9'(r_start)) < SPACE9;

    // status of the frame closed by the current checksum byte
    always_comb begin
        if (b != r_sum) begin
            status = ST_BAD_CKSUM;
        end else if ((9'(r_start) == 9'(i_capture_register)) &&
                     (r_len >= SW'(MEAS_BYTES))) begin
            status = ST_GOOD_LATCH;
        end else begin
            status = ST_GOOD_OTHER;
        end
    end

    // byte classification and parse state update
    always_comb begin
        n_pos      = r_pos;
        n_start    = r_start;
        n_len      = r_len;
        n_sum      = r_sum;
        n_stage    = r_stage;
        o_evt_push = 1'b0;
        if (accept) begin
            if (r_pos == P_HDR) begin
                if (b == i_header_byte) begin
                    n_sum = b;
                    n_pos = P_FUNC;
                end
            end else if (r_pos == P_FUNC) begin
                if (b == FUNC_READ) begin
                    n_sum = sum_b;
                    n_pos = P_START;
                end else begin
                    n_pos = P_HDR;
                end
            end else if (r_pos == P_START) begin
                if (start_ok) begin
                    n_start = b[SW-1:0];
                    n_sum   = sum_b;
                    n_pos   = P_LEN;
                end else begin
                    n_pos = P_HDR;
                end
            end else if (r_pos == P_LEN) begin
                if (len_ok) begin
                    n_len = b[SW-1:0];
                    n_sum = sum_b;
                    n_pos = PW'(HDR_BYTES);
                end else begin
                    n_pos = P_HDR;
                end
            end else if (in_data) begin
                // bytes past the measurement block are summed only
                if (data_idx < PW'(MEAS_BYTES)) begin
                    n_stage[data_idx[MEAS_IDX_W-1:0]] = b;
                end
                n_sum = sum_b;
                n_pos = r_pos + PW'(1);
            end else begin
                // checksum byte closes the frame
                o_evt_push = 1'b1;
                n_pos      = P_HDR;
            end
        end
    end

    assign o_evt.status = status;
    assign o_evt.meas   = r_stage;

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= P_HDR;
            r_start <= '0;
            r_len   <= '0;
            r_sum   <= '0;
        end else begin
            r_pos   <= n_pos;
            r_start <= n_start;
            r_len   <= n_len;
            r_sum   <= n_sum;
        end
    end

    // payload staging
    always_ff @(posedge i_clk) begin
        r_stage <= n_stage;
    end

endmodule

### rtl/irtfp_evt_fifo.sv
module irtfp_evt_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  irtfp_pkg::t_frame_evt i_evt,
    output logic                  o_full,
    output logic                  o_valid,
    input  logic                  i_pop,
    output irtfp_pkg::t_frame_evt o_evt
);
    import irtfp_pkg::*;

    t_frame_evt r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign push    = i_push & ~o_full;
    assign pop     = i_pop & o_valid;
    assign o_evt   = r_mem[r_rp];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_evt;
        end
    end

endmodule

### rtl/irtfp_back.sv
module irtfp_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_evt_valid,
    input  irtfp_pkg::t_frame_evt i_evt,
    output logic                  o_evt_pop,
    irtfp_stream_if.source        o_res
);
    import irtfp_pkg::*;

    logic        r_valid;
    logic [1:0]  r_status;
    logic [7:0]  r_emis;
    logic [15:0] r_obj;
    logic [15:0] r_amb;
    logic [15:0] r_body;

    // take the next frame when the output slot is free or being drained
    assign o_evt_pop = i_evt_valid & (~r_valid | o_res.ready);

    // output slot and held measurement
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_status <= ST_GOOD_LATCH;
            r_emis   <= '0;
            r_obj    <= '0;
            r_amb    <= '0;
            r_body   <= '0;
        end else if (o_evt_pop) begin
            r_valid  <= 1'b1;
            r_status <= i_evt.status;
            if (i_evt.status == ST_GOOD_LATCH) begin
                r_emis <= i_evt.meas[0];
                r_obj  <= {i_evt.meas[1], i_evt.meas[2]};
                r_amb  <= {i_evt.meas[3], i_evt.meas[4]};
                r_body <= {i_evt.meas[5], i_evt.meas[6]};
            end
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_res.valid                   = r_valid;
    assign o_res.data.status             = r_status;
    assign o_res.data.emissivity_raw     = r_emis;
    assign o_res.data.object_temp_centi  = r_obj;
    assign o_res.data.ambient_temp_centi = r_amb;
    assign o_res.data.body_temp_centi    = r_body;

endmodule

### test/ir_thermometer_frame_parser_top_test.sv
`timescale 1ns / 1ps

module ir_thermometer_frame_parser_top_test;
    import irtfp_pkg::*;

    localparam int unsigned REG_SPACE    = REGISTER_SPACE_DEF;
    localparam int unsigned RANDOM_BYTES = 400;
    localparam int unsigned PHASES       = 5;

    // frame parser prediction and result comparison
    class frame_result_board;
        logic [7:0]  hdr_cfg;
        logic [3:0]  cap_cfg;
        logic [4:0]  pos;
        logic [3:0]  frm_start;
        logic [3:0]  frm_len;
        logic [7:0]  sum;
        logic [7:0]  staged [MEAS_BYTES];
        logic [7:0]  emis;
        logic [15:0] obj_t;
        logic [15:0] amb_t;
        logic [15:0] body_t;
        t_result     pending_results [$];
        int unsigned errors;
        int unsigned bytes_in;
        int unsigned frames_checked;
        int unsigned status_cnt [3];

        function new();
            hdr_cfg = HEADER_BYTE_RST;
            cap_cfg = CAPTURE_REGISTER_RST;
            pos = '0;
            frm_start = '0;
            frm_len = '0;
            sum = '0;
            foreach (staged[k]) staged[k] = '0;
            emis = '0;
            obj_t = '0;
            amb_t = '0;
            body_t = '0;
            errors = 0;
            bytes_in = 0;
            frames_checked = 0;
            foreach (status_cnt[k]) status_cnt[k] = 0;
        endfunction

        function void set_config(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
            if (idx == CFG_HEADER_BYTE)
                hdr_cfg = val;
            else if (idx == CFG_CAPTURE_REGISTER)
                cap_cfg = val[3:0];
        endfunction

        // advance the parse by one received byte, queue a result on the checksum byte
        function void absorb_byte(logic [7:0] b);
            int unsigned idx;
            t_status     st;
            t_result     r;
            bytes_in++;
            if (pos == 0) begin
                if (b == hdr_cfg) begin
                    sum = b;
                    pos = 5'd1;
                end
            end else if (pos == 1) begin
                if (b == FUNC_READ) begin
                    sum = sum + b;
                    pos = 5'd2;
                end else begin
                    pos = 5'd0;
                end
            end else if (pos == 2) begin
                if (int'(b) < REG_SPACE) begin
                    frm_start = b[3:0];
                    sum = sum + b;
                    pos = 5'd3;
                end else begin
                    pos = 5'd0;
                end
            end else if (pos == 3) begin
                if (int'(frm_start) + int'(b) < REG_SPACE) begin
                    frm_len = b[3:0];
                    sum = sum + b;
                    pos = 5'd4;
                end else begin
                    pos = 5'd0;
                end
            end else if (int'(pos) < int'(frm_len) + HDR_BYTES) begin
                idx = pos - HDR_BYTES;
                if (idx < MEAS_BYTES)
                    staged[idx] = b;
                sum = sum + b;
                pos = pos + 5'd1;
            end else begin
                // checksum byte closes the frame
                pos = 5'd0;
                if (b != sum) begin
                    st = ST_BAD_CKSUM;
                end else if (frm_start == cap_cfg && frm_len >= MEAS_BYTES) begin
                    emis   = staged[0];
                    obj_t  = {staged[1], staged[2]};
                    amb_t  = {staged[3], staged[4]};
                    body_t = {staged[5], staged[6]};
                    st = ST_GOOD_LATCH;
                end else begin
                    st = ST_GOOD_OTHER;
                end
                status_cnt[st]++;
                r.status             = st;
                r.emissivity_raw     = emis;
                r.object_temp_centi  = obj_t;
                r.ambient_temp_centi = amb_t;
                r.body_temp_centi    = body_t;
                pending_results.push_back(r);
            end
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= 40)
                $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                report_mismatch("result with no completed frame pending");
                return;
            end
            want = pending_results.pop_front();
            frames_checked++;
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.emissivity_raw !== want.emissivity_raw)
                report_mismatch($sformatf("emissivity %h, want %h",
                                          got.emissivity_raw, want.emissivity_raw));
            if (got.object_temp_centi !== want.object_temp_centi)
                report_mismatch($sformatf("object temp %h, want %h",
                                          got.object_temp_centi, want.object_temp_centi));
            if (got.ambient_temp_centi !== want.ambient_temp_centi)
                report_mismatch($sformatf("ambient temp %h, want %h",
                                          got.ambient_temp_centi, want.ambient_temp_centi));
            if (got.body_temp_centi !== want.body_temp_centi)
                report_mismatch($sformatf("body temp %h, want %h",
                                          got.body_temp_centi, want.body_temp_centi));
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    irtfp_stream_if #(.T(t_rx_item)) rx_if ();
    irtfp_stream_if #(.T(t_result))  res_if ();

    frame_result_board sb;
    bit                steady;
    int unsigned       frame_bytes;

    ir_thermometer_frame_parser_top #(
        .REGISTER_SPACE(REG_SPACE)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_wdata(i_cfg_wdata),
        .i_rx       (rx_if),
        .o_res      (res_if)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("FAIL ir_thermometer_frame_parser_top");
        $finish;
    end

    // mostly short idle stretches, a few long ones
    function automatic int unsigned idle_length();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    // result side ready pattern
    initial begin
        int unsigned hold_cnt;
        hold_cnt = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cnt == 0) begin
                if (steady || $urandom_range(0, 9) < 6) begin
                    res_if.ready <= 1'b1;
                    hold_cnt = $urandom_range(1, 8);
                end else begin
                    res_if.ready <= 1'b0;
                    hold_cnt = idle_length();
                end
            end
            hold_cnt--;
        end
    end

    // byte transfers into the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && rx_if.valid && rx_if.ready)
            sb.absorb_byte(rx_if.data.rx_byte);
    end

    // result transfers against the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready)
            sb.check_result(res_if.data);
    end

    // one byte transfer, then an optional gap
    task automatic push_byte(input logic [7:0] b);
        int unsigned gap;
        rx_if.valid <= 1'b1;
        rx_if.data  <= t_rx_item'(b);
        do @(posedge i_clk); while (rx_if.ready !== 1'b1);
        gap = (steady || $urandom_range(0, 3) != 0) ? 0 : idle_length();
        if (gap != 0) begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop sending and let every pending result come out
    task automatic drain();
        rx_if.valid <= 1'b0;
        // let the last byte transfer reach the predictor first
        @(posedge i_clk);
        while (sb.pending_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [7:0] hdr, input logic [3:0] cap);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_HEADER_BYTE;
        i_cfg_wdata <= hdr;
        @(posedge i_clk);
        sb.set_config(CFG_HEADER_BYTE, hdr);
        i_cfg_index <= CFG_CAPTURE_REGISTER;
        i_cfg_wdata <= {4'b0, cap};
        @(posedge i_clk);
        sb.set_config(CFG_CAPTURE_REGISTER, {4'b0, cap});
        i_cfg_we    <= 1'b0;
    endtask

    // full frame; pattern gives all-ones and all-zero measurement fields
    task automatic send_frame(input int unsigned start, input int unsigned len,
                              input bit corrupt, input bit pattern);
        logic [7:0] sum;
        logic [7:0] b;
        sum = sb.hdr_cfg + FUNC_READ + start[7:0] + len[7:0];
        push_byte(sb.hdr_cfg);
        push_byte(FUNC_READ);
        push_byte(start[7:0]);
        push_byte(len[7:0]);
        for (int unsigned k = 0; k < len; k++) begin
            if (pattern)
                b = (k == 3 || k == 4) ? 8'h00 : 8'hFF;
            else
                b = 8'($urandom_range(0, 255));
            sum = sum + b;
            push_byte(b);
        end
        push_byte(corrupt ? sum + 8'($urandom_range(1, 255)) : sum);
        frame_bytes += len + 5;
    endtask

    // frame with random content, biased toward measurement frames
    task automatic send_random_frame();
        int unsigned start;
        int unsigned max_len;
        int unsigned len;
        if ($urandom_range(0, 9) < 4)
            start = sb.cap_cfg;
        else
            start = $urandom_range(0, REG_SPACE - 1);
        max_len = REG_SPACE - 1 - start;
        if (start == sb.cap_cfg && max_len >= MEAS_BYTES && $urandom_range(0, 9) < 7)
            len = $urandom_range(MEAS_BYTES, max_len);
        else
            len = $urandom_range(0, max_len);
        send_frame(start, len, $urandom_range(0, 7) == 0, 1'b0);
    endtask

    // frame cut off by a bad function, start or length byte
    task automatic send_broken(input int unsigned kind);
        logic [7:0]  b;
        int unsigned s;
        push_byte(sb.hdr_cfg);
        if (kind == 0) begin
            b = 8'($urandom_range(0, 255));
            if (b == FUNC_READ)
                b = 8'h83;
            push_byte(b);
            frame_bytes += 2;
        end else if (kind == 1) begin
            push_byte(FUNC_READ);
            push_byte(8'($urandom_range(REG_SPACE, 255)));
            frame_bytes += 3;
        end else begin
            s = $urandom_range(0, REG_SPACE - 1);
            push_byte(FUNC_READ);
            push_byte(s[7:0]);
            push_byte(8'($urandom_range(REG_SPACE - s, 255)));
            frame_bytes += 4;
        end
    endtask

    // stimulus
    initial begin
        logic [7:0]  hdr;
        logic [3:0]  cap;
        int unsigned pick;
        sb = new();
        steady = 1'b0;
        frame_bytes = 0;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_HEADER_BYTE;
        i_cfg_wdata <= '0;
        rx_if.valid <= 1'b0;
        rx_if.data  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: wrong header bytes, a repeated header as bad function byte
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(sb.hdr_cfg);
        push_byte(sb.hdr_cfg);
        push_byte(FUNC_READ);
        // start register just out of range, then length overflow
        push_byte(sb.hdr_cfg);
        push_byte(FUNC_READ);
        push_byte(8'(REG_SPACE));
        push_byte(sb.hdr_cfg);
        push_byte(FUNC_READ);
        push_byte(8'(REG_SPACE - 1));
        push_byte(8'h01);
        // measurement frame with extreme values, then an empty frame with bad checksum
        send_frame(sb.cap_cfg, MEAS_BYTES, 1'b0, 1'b1);
        send_frame(0, 0, 1'b1, 1'b0);
        drain();

        // random phases, each under its own register setting
        frame_bytes = 0;
        for (int unsigned ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin hdr = 8'h00; cap = 4'd0; end
                1: begin hdr = 8'hFF; cap = 4'd15; end
                2: begin hdr = HEADER_BYTE_RST; cap = 4'd8; end
                default: begin
                    hdr = 8'($urandom_range(0, 255));
                    cap = 4'($urandom_range(0, 8));
                end
            endcase
            write_config(hdr, cap);
            steady = (ph == 0);
            while (frame_bytes < RANDOM_BYTES * (ph + 1) / PHASES) begin
                pick = $urandom_range(0, 19);
                if (pick < 15)
                    send_random_frame();
                else if (pick < 18)
                    send_broken($urandom_range(0, 2));
                else
                    repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
            end
            drain();
        end

        $display("run covered %0d byte transfers over %0d register settings, %0d frames checked",
                 sb.bytes_in, PHASES + 1, sb.frames_checked);
        $display("frame outcomes: %0d latched, %0d good without latch, %0d bad checksum",
                 sb.status_cnt[ST_GOOD_LATCH], sb.status_cnt[ST_GOOD_OTHER],
                 sb.status_cnt[ST_BAD_CKSUM]);
        if (sb.errors == 0)
            $display("PASS ir_thermometer_frame_parser_top");
        else
            $display("FAIL ir_thermometer_frame_parser_top");
        $finish;
    end

endmodule

### ir_thermometer_frame_parser_top.f
rtl/irtfp_pkg.sv
rtl/irtfp_stream_if.sv
rtl/irtfp_front.sv
rtl/irtfp_evt_fifo.sv
rtl/irtfp_back.sv
rtl/ir_thermometer_frame_parser_top.sv
test/ir_thermometer_frame_parser_top_test.sv
